/* design/scp_pkg.sv */
`timescale 1ns / 1ps
package scp_pkg;

  localparam int COS_TABLE_BITS_DEF = 10;
  localparam int LANES              = 3;
  localparam int DIV_STEPS          = 16;
  // front stages (error/angle math, cosine, voltage), divider steps, output register
  localparam int DIV_FIRST          = 11;
  localparam int PIPE_STAGES        = DIV_FIRST + DIV_STEPS + 1;

  typedef logic        [15:0] angle_t;
  typedef logic signed [16:0] perr_t;
  typedef logic        [15:0] duty_t;
  typedef logic        [15:0] cfg_data_t;
  typedef logic        [2:0]  cfg_index_t;

  typedef enum logic [2:0] {
    CFG_MOTOR_PAIRS  = 3'd0,
    CFG_ANGLE_OFFSET = 3'd1,
    CFG_KP_GAIN      = 3'd2,
    CFG_PWM_TOP      = 3'd3,
    CFG_BUS_MV       = 3'd4,
    CFG_HALF_BUS_MV  = 3'd5
  } cfg_reg_t;

  localparam logic [5:0]  MOTOR_PAIRS_RST  = 6'd11;
  localparam logic [15:0] ANGLE_OFFSET_RST = 16'd23807;
  localparam logic [15:0] KP_GAIN_RST      = 16'd256;
  localparam logic [15:0] PWM_TOP_RST      = 16'd1000;
  localparam logic [15:0] BUS_MV_RST       = 16'd12000;
  localparam logic [14:0] HALF_BUS_MV_RST  = 15'd6000;

  // angles in hundredths of a degree
  localparam logic [15:0] TURN         = 16'd36000;
  localparam logic [15:0] THIRD_TURN   = 16'd12000;
  localparam logic [15:0] TWO_THIRDS   = 16'd24000;
  localparam logic [15:0] QUARTER_TURN = 16'd9000;

  // floor(2^28 / 36000) and floor(2^32 / 36000); estimates are low by at most one
  localparam logic [12:0] RECIP_28 = 13'd7456;
  localparam logic [16:0] RECIP_32 = 17'd119304;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  function automatic longint unsigned taylor_div(longint unsigned v, int unsigned k);
    longint unsigned q;
    case (k)
      0:       q = v / 2;
      1:       q = v / 6;
      2:       q = v / 12;
      3:       q = v / 20;
      4:       q = v / 30;
      5:       q = v / 42;
      6:       q = v / 56;
      7:       q = v / 72;
      8:       q = v / 90;
      9:       q = v / 110;
      10:      q = v / 132;
      11:      q = v / 156;
      12:      q = v / 182;
      13:      q = v / 210;
      default: q = v;
    endcase
    return q;
  endfunction

  // Q0.15 magnitude of cos (or sin) at quarter-wave step r, Taylor series in Q30
  function automatic logic [14:0] cos_mag(int unsigned r, int unsigned nbits, bit want_sin);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint          sum;
    int unsigned     k;
    bit              neg;
    x    = (longint'(r) * PI_Q30 * 64'd2) >> nbits;
    x2   = (x * x) >> 30;
    term = want_sin ? x : (64'd1 << 30);
    k    = want_sin ? 1 : 0;
    sum  = longint'(term);
    neg  = 1'b1;
    for (int n = 0; n < 7; n++) begin
      term = taylor_div((term * x2) >> 30, k);
      k    = k + 2;
      sum  = neg ? sum - longint'(term) : sum + longint'(term);
      neg  = !neg;
    end
    if (sum < 0) sum = 0;
    mag = (longint'(sum) + 64'd16384) >> 15;
    if (mag > 64'd32767) mag = 64'd32767;
    return 15'(mag);
  endfunction

endpackage

/* design/scp_in_if.sv */
`timescale 1ns / 1ps
interface scp_in_if;
  import scp_pkg::*;

  logic   valid;
  logic   ready;
  angle_t rotor_angle;
  perr_t  position_error;

  modport source (output valid, output rotor_angle, output position_error, input ready);
  modport sink   (input valid, input rotor_angle, input position_error, output ready);
endinterface

/* design/scp_out_if.sv */
`timescale 1ns / 1ps
interface scp_out_if;
  import scp_pkg::*;

  logic  valid;
  logic  ready;
  duty_t duty_a;
  duty_t duty_b;
  duty_t duty_c;
  logic  voltage_limited;

  modport source (output valid, output duty_a, output duty_b, output duty_c,
                  output voltage_limited, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                  input voltage_limited, output ready);
endinterface

/* design/scp_cfg_if.sv */
`timescale 1ns / 1ps
interface scp_cfg_if;
  import scp_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/sinusoidal_commutation_p_loop.sv */
// Sinusoidal three-phase commutation with a proportional position loop. Each
// transaction (rotor angle, position error) yields one transaction of three PWM
// compare values and a limit flag. The block takes one transaction per clock
// when the output side does not stall and passes it through 11 stages of
// error/voltage math, electrical angle reduction, cosine lookup and phase scaling,
// then a 16-step restoring divider (one quotient bit per stage, one per phase)
// that divides by the bus voltage, then the output register. A stall holds only
// the stages that are full, so bubbles are squeezed out. Configuration writes are
// taken every cycle and must only be issued while the pipeline is empty.
`timescale 1ns / 1ps
module sinusoidal_commutation_p_loop #(
  parameter int COS_TABLE_BITS = scp_pkg::COS_TABLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  scp_cfg_if.sink   cfg,
  scp_in_if.sink    sample,
  scp_out_if.source duty
);
  import scp_pkg::*;

  localparam int NS     = PIPE_STAGES;
  localparam int TB     = COS_TABLE_BITS;
  localparam int QB     = TB - 2;
  localparam int QDEPTH = 1 << QB;
  localparam int LW     = TB + 17;

  // ---------------------------------------------------------------- config
  logic [5:0]  motor_pairs;
  logic [15:0] angle_offset;
  logic [15:0] kp_gain;
  logic [15:0] pwm_top;
  logic [15:0] bus_mv;
  logic [14:0] half_bus_mv;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_pairs  <= MOTOR_PAIRS_RST;
      angle_offset <= ANGLE_OFFSET_RST;
      kp_gain      <= KP_GAIN_RST;
      pwm_top      <= PWM_TOP_RST;
      bus_mv       <= BUS_MV_RST;
      half_bus_mv  <= HALF_BUS_MV_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MOTOR_PAIRS:  motor_pairs  <= cfg.data[5:0];
        CFG_ANGLE_OFFSET: angle_offset <= cfg.data;
        CFG_KP_GAIN:      kp_gain      <= cfg.data;
        CFG_PWM_TOP:      pwm_top      <= cfg.data;
        CFG_BUS_MV:       bus_mv       <= cfg.data;
        CFG_HALF_BUS_MV:  half_bus_mv  <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- pipeline control
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // a stage may load when the output is ready or when it or any stage after it holds a bubble
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = duty.ready | ~(&vld[NS-1:k]);
  end

  assign sample.ready = en[0];
  assign duty.valid   = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (en & {vld[NS-2:0], sample.valid}) | (~en & vld);
    end
  end

  // flags and the clamped vq that ride along
  logic              lim_pipe [1:NS-1];
  logic signed [15:0] vq_pipe [1:7];

  // ------------------------------------------- stage 0: wrap, gain, angle diff
  logic signed [16:0] err_w;
  logic signed [17:0] dang;
  logic [15:0]        dmod_c;
  logic signed [33:0] prod0;
  logic [15:0]        dmod0;

  assign dang = $signed({2'b00, sample.rotor_angle}) - $signed({2'b00, angle_offset});

  always_comb begin
    err_w = sample.position_error;
    if (sample.position_error > 17'sd18000) begin
      err_w = sample.position_error - 17'sd36000;
    end else if (sample.position_error < -17'sd18000) begin
      err_w = sample.position_error + 17'sd36000;
    end
    if (dang < -18'sd36000) begin
      dmod_c = 16'(dang + 18'sd72000);
    end else if (dang < 18'sd0) begin
      dmod_c = 16'(dang + 18'sd36000);
    end else if (dang < 18'sd36000) begin
      dmod_c = 16'(dang);
    end else begin
      dmod_c = 16'(dang - 18'sd36000);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod0 <= $signed({1'b0, kp_gain}) * err_w;
      dmod0 <= dmod_c;
    end
  end

  // ------------------------------------ stage 1: clamp vq, electrical angle
  logic signed [25:0] vq_full;
  logic signed [25:0] half_s;
  logic signed [15:0] vq_c;
  logic               lim_c;
  logic [21:0]        x_c;
  logic [21:0]        x1;

  assign vq_full = prod0[33:8];  // floor of /256
  assign half_s  = $signed({11'b0, half_bus_mv});
  assign x_c     = dmod0 * motor_pairs + 22'(QUARTER_TURN);

  always_comb begin
    vq_c  = 16'(vq_full);
    lim_c = 1'b0;
    if (vq_full > half_s) begin
      vq_c  = 16'(half_s);
      lim_c = 1'b1;
    end else if (vq_full < -half_s) begin
      vq_c  = 16'(-half_s);
      lim_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vq_pipe[1]  <= vq_c;
      lim_pipe[1] <= lim_c;
      x1          <= x_c;
    end
    for (int k = 2; k < NS; k++) begin
      if (en[k]) lim_pipe[k] <= lim_pipe[k-1];
    end
    for (int k = 2; k < 8; k++) begin
      if (en[k]) vq_pipe[k] <= vq_pipe[k-1];
    end
  end

  // ------------------------------- stages 2-3: electrical angle mod a turn
  logic [34:0] qprod;
  logic [21:0] x2;
  logic [5:0]  qe2;
  logic [21:0] qmul;
  logic [16:0] rem_c;
  logic [15:0] ea3;

  assign qprod = x1 * RECIP_28;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x2  <= x1;
      qe2 <= qprod[33:28];
    end
  end

  assign qmul  = qe2 * TURN;
  assign rem_c = 17'(x2 - qmul);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ea3 <= (rem_c >= 17'(TURN)) ? 16'(rem_c - 17'(TURN)) : rem_c[15:0];
    end
  end

  // --------------------------------------------------- stage 4: phase angles
  logic [15:0] ang4 [LANES];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ang4[0] <= ea3;
      ang4[1] <= (ea3 >= THIRD_TURN) ? ea3 - THIRD_TURN : ea3 + TWO_THIRDS;
      ang4[2] <= (ea3 >= TWO_THIRDS) ? ea3 - TWO_THIRDS : ea3 + THIRD_TURN;
    end
  end

  // ------------------------------- stages 5-6: table step = ang * 2^TB / turn
  logic [32:0]    iprod [LANES];
  logic [15:0]    ang5  [LANES];
  logic [TB-1:0]  ie5   [LANES];
  logic [LW-1:0]  lhs   [LANES];
  logic [LW-1:0]  rhs   [LANES];
  logic [TB-1:0]  idx6  [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_idx
    assign iprod[l] = ang4[l] * RECIP_32;
    assign lhs[l]   = LW'(ie5[l]) * LW'(TURN) + LW'(TURN);
    assign rhs[l]   = LW'({ang5[l], {TB{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int l = 0; l < LANES; l++) begin
        ang5[l] <= ang4[l];
        ie5[l]  <= iprod[l][31 -: TB];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int l = 0; l < LANES; l++) begin
        idx6[l] <= (lhs[l] <= rhs[l]) ? ie5[l] + 1'b1 : ie5[l];
      end
    end
  end

  // ------------------------------------------------ stage 7: cosine lookup
  logic [14:0]        cos_lut [QDEPTH];
  logic [14:0]        sin_lut [QDEPTH];
  logic [14:0]        mag_c   [LANES];
  logic signed [15:0] cosv7   [LANES];

  for (genvar g = 0; g < QDEPTH; g++) begin : g_lut
    assign cos_lut[g] = cos_mag(g, TB, 1'b0);
    assign sin_lut[g] = cos_mag(g, TB, 1'b1);
  end

  // quadrants: cos, -sin, -cos, sin
  for (genvar l = 0; l < LANES; l++) begin : g_cos
    assign mag_c[l] = idx6[l][QB] ? sin_lut[idx6[l][QB-1:0]] : cos_lut[idx6[l][QB-1:0]];
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int l = 0; l < LANES; l++) begin
        cosv7[l] <= (idx6[l][TB-1] ^ idx6[l][QB]) ? -$signed({1'b0, mag_c[l]})
                                                  : $signed({1'b0, mag_c[l]});
      end
    end
  end

  // ------------------------------------------- stages 8-10: phase voltages
  logic signed [31:0] p8    [LANES];
  logic signed [17:0] v_c   [LANES];
  logic [15:0]        v9    [LANES];
  logic               zero9 [LANES];
  logic               sat9  [LANES];
  logic [31:0]        n10   [LANES];
  logic               zero10[LANES];
  logic               sat10 [LANES];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int l = 0; l < LANES; l++) begin
        p8[l] <= vq_pipe[7] * cosv7[l];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_volt
    assign v_c[l] = $signed({p8[l][31], p8[l][31:15]}) + $signed({3'b000, half_bus_mv});
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int l = 0; l < LANES; l++) begin
        v9[l]    <= v_c[l][15:0];
        zero9[l] <= (bus_mv == '0) || (v_c[l] <= 18'sd0);
        sat9[l]  <= v_c[l][15:0] >= bus_mv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      for (int l = 0; l < LANES; l++) begin
        n10[l]    <= v9[l] * pwm_top;
        zero10[l] <= zero9[l];
        sat10[l]  <= sat9[l];
      end
    end
  end

  // ------------------------------ stages 11-26: restoring divide by bus_mv
  // v < bus_mv here unless the lane is saturated (its duty is then set to pwm_top or 0),
  // so the quotient fits 16 bits and the high half of the dividend starts below the divisor.
  logic [15:0] drem  [DIV_STEPS-1][LANES];
  logic [15:0] dlow  [DIV_STEPS-1][LANES];
  logic [15:0] dquo  [DIV_STEPS][LANES];
  logic        dzero [DIV_STEPS][LANES];
  logic        dsat  [DIV_STEPS][LANES];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [15:0] rem_in;
      logic [15:0] low_in;
      logic [15:0] quo_in;
      logic        zero_in;
      logic        sat_in;
      logic [16:0] trial;
      logic        take;

      if (j == 0) begin : g_first
        assign rem_in  = n10[l][31:16];
        assign low_in  = n10[l][15:0];
        assign quo_in  = '0;
        assign zero_in = zero10[l];
        assign sat_in  = sat10[l];
      end else begin : g_next
        assign rem_in  = drem[j-1][l];
        assign low_in  = dlow[j-1][l];
        assign quo_in  = dquo[j-1][l];
        assign zero_in = dzero[j-1][l];
        assign sat_in  = dsat[j-1][l];
      end

      assign trial = {rem_in, low_in[DIV_STEPS-1-j]};
      assign take  = trial >= {1'b0, bus_mv};

      always_ff @(posedge clk) begin
        if (en[DIV_FIRST+j]) begin
          dquo[j][l]  <= {quo_in[14:0], take};
          dzero[j][l] <= zero_in;
          dsat[j][l]  <= sat_in;
        end
      end

      if (j < DIV_STEPS - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en[DIV_FIRST+j]) begin
            drem[j][l] <= take ? 16'(trial - {1'b0, bus_mv}) : trial[15:0];
            dlow[j][l] <= low_in;
          end
        end
      end
    end
  end

  // ------------------------------------------------------- output register
  duty_t duty_r [LANES];

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      for (int l = 0; l < LANES; l++) begin
        if (dzero[DIV_STEPS-1][l]) begin
          duty_r[l] <= '0;
        end else if (dsat[DIV_STEPS-1][l]) begin
          duty_r[l] <= pwm_top;
        end else begin
          duty_r[l] <= dquo[DIV_STEPS-1][l];
        end
      end
    end
  end

  assign duty.duty_a          = duty_r[0];
  assign duty.duty_b          = duty_r[1];
  assign duty.duty_c          = duty_r[2];
  assign duty.voltage_limited = lim_pipe[NS-1];

endmodule

/* design/scp_checker.sv */
`timescale 1ns / 1ps
module scp_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input scp_pkg::duty_t      duty_a,
  input scp_pkg::duty_t      duty_b,
  input scp_pkg::duty_t      duty_c,
  input logic                voltage_limited,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input scp_pkg::cfg_index_t cfg_index,
  input scp_pkg::cfg_data_t  cfg_data
);
  import scp_pkg::*;

  logic [5:0]  cnt;
  logic [5:0]  cnt_next;
  logic [15:0] period;

  assign cnt_next = 6'(cnt + (in_valid & in_ready) - (out_valid & out_ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      period <= PWM_TOP_RST;
    end else begin
      cnt <= cnt_next;
      if (cfg_valid && cfg_ready && cfg_index == CFG_PWM_TOP) period <= cfg_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty_a) && $stable(duty_b)
                                && $stable(duty_c) && $stable(voltage_limited))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cnt != 6'd0)
    else $error("result with no transaction in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    cnt <= 6'(PIPE_STAGES))
    else $error("more transactions in flight than pipeline stages");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty_a <= period && duty_b <= period && duty_c <= period)
    else $error("duty above PWM period");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

endmodule

bind sinusoidal_commutation_p_loop scp_checker u_scp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (sample.valid),
  .in_ready        (sample.ready),
  .out_valid       (duty.valid),
  .out_ready       (duty.ready),
  .duty_a          (duty.duty_a),
  .duty_b          (duty.duty_b),
  .duty_c          (duty.duty_c),
  .voltage_limited (duty.voltage_limited),
  .cfg_valid       (cfg.valid),
  .cfg_ready       (cfg.ready),
  .cfg_index       (cfg.index),
  .cfg_data        (cfg.data)
);

/* tb/scp_duty_checker.sv */
`timescale 1ns / 1ps
module scp_duty_checker (
  input  logic clk,
  input  logic rst,
  scp_cfg_if   cfg,
  scp_in_if    sample,
  scp_out_if   duty,
  output int   fail_count,
  output int   in_flight
);
  import scp_pkg::*;

  localparam int              TBITS        = COS_TABLE_BITS_DEF;
  localparam int              STEPS        = 1 << TBITS;
  localparam longint          FULL_CDEG    = 36000;
  localparam longint          HALF_CDEG    = 18000;
  localparam longint          QUARTER_CDEG = 9000;
  localparam longint          THIRD_CDEG   = 12000;
  localparam longint unsigned PI_Q30_VAL   = 64'd3373259426;
  localparam int              PRINT_CAP    = 40;

  typedef struct packed {
    duty_t duty_a;
    duty_t duty_b;
    duty_t duty_c;
    logic  voltage_limited;
  } duty_set_t;

  duty_set_t duty_queue[$];
  int        cos_q15_tab[STEPS];

  longint motor_pairs_r;
  longint angle_offset_r;
  longint kp_gain_r;
  longint pwm_top_r;
  longint bus_mv_r;
  longint half_bus_r;

  // sin/cos power series in Q30 over the first quadrant, each term floored
  function automatic longint series_q30(longint unsigned x, bit odd);
    longint unsigned x_sq;
    longint unsigned t;
    longint          acc;
    int unsigned     p;
    x_sq = (x * x) >> 30;
    t    = odd ? x : 64'd1 << 30;
    p    = odd ? 1 : 0;
    acc  = t;
    for (int n = 0; n < 7; n++) begin
      t   = ((t * x_sq) >> 30) / ((p + 1) * (p + 2));
      p   = p + 2;
      acc = (n % 2 == 0) ? acc - t : acc + t;
    end
    return (acc < 0) ? 0 : acc;
  endfunction

  function automatic int cos_step(int unsigned idx);
    int unsigned     quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned mag;
    quad = (idx >> (TBITS - 2)) & 3;
    r    = idx & ((STEPS >> 2) - 1);
    x    = (r * PI_Q30_VAL * 64'd2) >> TBITS;
    // odd quadrants use sin of the remainder, quadrants 1 and 2 are negative
    mag  = series_q30(x, quad[0]);
    mag  = (mag + 64'd16384) >> 15;
    if (mag > 64'd32767) mag = 64'd32767;
    return (quad[0] ^ quad[1]) ? -int'(mag) : int'(mag);
  endfunction

  function automatic longint cos_at(longint ang);
    return cos_q15_tab[((ang % FULL_CDEG) * STEPS) / FULL_CDEG];
  endfunction

  function automatic duty_t phase_duty(longint vq, longint ang);
    longint v;
    longint d;
    v = ((vq * cos_at(ang)) >>> 15) + half_bus_r;
    if (bus_mv_r == 0 || v <= 0) return '0;
    d = (v * pwm_top_r) / bus_mv_r;
    if (d > pwm_top_r) d = pwm_top_r;
    return duty_t'(d);
  endfunction

  function automatic duty_set_t predict_duties(longint angle, longint err_in);
    longint    err;
    longint    vq;
    longint    elec;
    duty_set_t r;
    err = err_in;
    r.voltage_limited = 1'b0;
    // single wrap only, far-out errors stay out of range
    if (err > HALF_CDEG) err = err - FULL_CDEG;
    else if (err < -HALF_CDEG) err = err + FULL_CDEG;
    vq = (kp_gain_r * err) >>> 8;
    if (vq > half_bus_r) begin
      vq = half_bus_r;
      r.voltage_limited = 1'b1;
    end
    if (vq < -half_bus_r) begin
      vq = -half_bus_r;
      r.voltage_limited = 1'b1;
    end
    elec = ((angle - angle_offset_r) * motor_pairs_r + QUARTER_CDEG) % FULL_CDEG;
    if (elec < 0) elec = elec + FULL_CDEG;
    r.duty_a = phase_duty(vq, elec);
    r.duty_b = phase_duty(vq, elec + FULL_CDEG - THIRD_CDEG);
    r.duty_c = phase_duty(vq, elec + THIRD_CDEG);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, longint want);
    if (fail_count < PRINT_CAP)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    for (int i = 0; i < STEPS; i++) cos_q15_tab[i] = cos_step(i);
  end

  always @(posedge clk) begin
    duty_set_t want;
    if (rst) begin
      motor_pairs_r  = MOTOR_PAIRS_RST;
      angle_offset_r = ANGLE_OFFSET_RST;
      kp_gain_r      = KP_GAIN_RST;
      pwm_top_r      = PWM_TOP_RST;
      bus_mv_r       = BUS_MV_RST;
      half_bus_r     = HALF_BUS_MV_RST;
      duty_queue.delete();
      fail_count     = 0;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          CFG_MOTOR_PAIRS:  motor_pairs_r  = longint'(cfg.data[5:0]);
          CFG_ANGLE_OFFSET: angle_offset_r = longint'(cfg.data);
          CFG_KP_GAIN:      kp_gain_r      = longint'(cfg.data);
          CFG_PWM_TOP:      pwm_top_r      = longint'(cfg.data);
          CFG_BUS_MV:       bus_mv_r       = longint'(cfg.data);
          CFG_HALF_BUS_MV:  half_bus_r     = longint'(cfg.data[14:0]);
          default: ;
        endcase
      end
      // compare before pushing so a same-cycle result can't match a fresh entry
      if (duty.valid === 1'b1 && duty.ready === 1'b1) begin
        if (duty_queue.size() == 0) begin
          report_mismatch("unexpected transaction, duty_a", duty.duty_a, -1);
        end else begin
          want = duty_queue.pop_front();
          if (duty.duty_a !== want.duty_a)
            report_mismatch("duty_a", duty.duty_a, want.duty_a);
          if (duty.duty_b !== want.duty_b)
            report_mismatch("duty_b", duty.duty_b, want.duty_b);
          if (duty.duty_c !== want.duty_c)
            report_mismatch("duty_c", duty.duty_c, want.duty_c);
          if (duty.voltage_limited !== want.voltage_limited)
            report_mismatch("voltage_limited", 16'(duty.voltage_limited),
                            want.voltage_limited);
        end
      end
      if (sample.valid === 1'b1 && sample.ready === 1'b1)
        duty_queue.push_back(predict_duties(longint'(sample.rotor_angle),
                                            longint'(sample.position_error)));
    end
    in_flight = duty_queue.size();
  end

endmodule

/* tb/tb_sinusoidal_commutation_p_loop.sv */
`timescale 1ns / 1ps
module tb_sinusoidal_commutation_p_loop;
  import scp_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 2 * PIPE_STAGES + 10;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 152;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   in_flight;
  int   src_idle_pct;
  int   snk_stall_pct;
  int   hold_req;
  int   hold_done;
  int   cycle_cnt;

  scp_cfg_if cfg_ch ();
  scp_in_if  sample_ch ();
  scp_out_if duty_ch ();

  sinusoidal_commutation_p_loop uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (sample_ch),
    .duty   (duty_ch)
  );

  scp_duty_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .sample     (sample_ch),
    .duty       (duty_ch),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // output side: random stalls, plus a long hold-off when requested
  initial begin : result_sink
    duty_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_req) begin
        duty_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        duty_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_sample(angle_t angle, perr_t err);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
    end
    @(negedge clk);
    sample_ch.valid          <= 1'b1;
    sample_ch.rotor_angle    <= angle;
    sample_ch.position_error <= err;
    @(posedge clk);
    while (sample_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_random_sample();
    int     pick;
    int     err;
    angle_t angle;
    pick  = $urandom_range(99);
    angle = ($urandom_range(99) < 85) ? angle_t'($urandom_range(35999)) : angle_t'($urandom);
    if (pick < 30)
      err = int'($urandom_range(400)) - 200;
    else if (pick < 75)
      err = int'($urandom_range(72000)) - 36000;
    else if (pick < 85)
      err = ($urandom_range(1) ? 18000 : -18000) + int'($urandom_range(4)) - 2;
    else
      err = int'($urandom);
    send_sample(angle, perr_t'(err));
  endtask

  // stop offering and wait for every pending transaction to come back
  task automatic drain_results();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int unsigned v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= cfg_data_t'(v);
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all(int unsigned pp, int unsigned offs, int unsigned kp,
                           int unsigned period, int unsigned bus, int unsigned half);
    write_reg(CFG_MOTOR_PAIRS, pp);
    write_reg(CFG_ANGLE_OFFSET, offs);
    write_reg(CFG_KP_GAIN, kp);
    write_reg(CFG_PWM_TOP, period);
    write_reg(CFG_BUS_MV, bus);
    write_reg(CFG_HALF_BUS_MV, half);
  endtask

  task automatic load_phase_settings(int phase);
    case (phase)
      0: write_all(MOTOR_PAIRS_RST, ANGLE_OFFSET_RST, KP_GAIN_RST, PWM_TOP_RST,
                   BUS_MV_RST, HALF_BUS_MV_RST);
      1: write_all(63, 65535, 65535, 65535, 65535, 32767);
      2: write_all(1, 0, 0, 1, 1000, 500);
      3: write_all(0, 9000, 512, 2000, 24000, 12000);   // electrical angle pinned
      4: write_all(4, 1000, 300, 1000, 0, 6000);        // no bus voltage
      5: write_all(7, 18000, 256, 0, 12000, 6000);      // no PWM period
      6: write_all(32, 35999, 128, 65535, 60000, 30000);
      default: write_all($urandom_range(32, 1), $urandom_range(35999),
                         $urandom_range(1) ? $urandom_range(1024) : $urandom_range(65535),
                         $urandom_range(65535, 1), $urandom_range(60000, 1000),
                         $urandom_range(30000, 500));
    endcase
  endtask

  initial begin : stimulus
    rst                      = 1'b1;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = CFG_MOTOR_PAIRS;
    cfg_ch.data              = '0;
    sample_ch.valid          = 1'b0;
    sample_ch.rotor_angle    = '0;
    sample_ch.position_error = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: kp 1.0, limit 6000 mV
    send_sample(16'd0, perr_t'(0));
    send_sample(16'd35999, perr_t'(1));
    send_sample(16'd65535, perr_t'(-1));
    send_sample(16'd18000, perr_t'(5999));
    send_sample(16'd9000, perr_t'(6000));
    send_sample(16'd27000, perr_t'(6001));
    send_sample(16'd12345, perr_t'(-6001));
    send_sample(16'd100, perr_t'(18000));
    send_sample(16'd200, perr_t'(18001));
    send_sample(16'd300, perr_t'(-18000));
    send_sample(16'd400, perr_t'(-18001));
    send_sample(16'd500, perr_t'(36000));
    send_sample(16'd600, perr_t'(-36000));
    send_sample(16'd700, perr_t'(65535));
    send_sample(16'd800, perr_t'(-65536));
    send_sample(16'd32768, perr_t'(12345));
    send_sample(16'd23807, perr_t'(-2500));
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_phase_settings(phase);
      case (phase % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 60;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 60;
        end
        default: begin
          src_idle_pct  = 16;
          snk_stall_pct = 16;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 40) hold_req++;
        if (phase == 8 && n == 76) drain_results();
        send_random_sample();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/scp_pkg.sv
design/scp_in_if.sv
design/scp_out_if.sv
design/scp_cfg_if.sv
design/sinusoidal_commutation_p_loop.sv
design/scp_checker.sv
tb/scp_duty_checker.sv
tb/tb_sinusoidal_commutation_p_loop.sv
